// ----- rtl/rra_pkg.sv -----
// Shared types and constants for the relative rank assigner.
// Holds the controller state encoding, the controller/datapath command and
// status structs, and the medal codes. No dependencies.
package rra_pkg;

  // Field widths of the stream items
  localparam int SCORE_W    = 32;
  localparam int POSITION_W = 6;
  localparam int PLACE_W    = 7;
  localparam int MEDAL_W    = 2;
  localparam int OUT_DATA_W = 16;

  // Compare bits are summed in groups of this many per pipeline stage
  localparam int GROUP_SIZE = 8;
  localparam int GROUP_W    = 4;

  // Medal codes
  localparam logic [MEDAL_W-1:0] MEDAL_NONE   = 2'd0;
  localparam logic [MEDAL_W-1:0] MEDAL_GOLD   = 2'd1;
  localparam logic [MEDAL_W-1:0] MEDAL_SILVER = 2'd2;
  localparam logic [MEDAL_W-1:0] MEDAL_BRONZE = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // an input item is accepted this cycle
    logic shift;  // a non-final result is taken: advance to the next entry
    logic clear;  // the final result is taken: start a new set
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic busy;      // rank-count pipeline still holds an entry
    logic last_res;  // the entry at the head is the final one of the set
  } dp_status_t;

endpackage

// ----- rtl/relative_rank_assigner_top.sv -----
// Relative rank assigner: ranks a set of signed scores in descending order.
// Depends on rra_pkg, rra_ctrl and rra_datapath.
//
// Usage:
//   Input channel (in_*): one signed 32-bit score per item, in_tlast on the
//   final score of a set. Scores beyond MAX_ITEMS are dropped.
//   Output channel (out_*): after the set ends, one result per stored score
//   in arrival order, carrying arrival index, place (1 is highest), medal
//   code and the overflow flag; out_tlast marks the last result of the set.
//   Equal scores rank in arrival order.
// Timing:
//   Scores are taken one per cycle; every cell compares against the new
//   score in parallel. The earlier-rank count of each score settles through
//   the registered popcount tree (compare bits, group sums, cell count);
//   results start once the tree has drained. Results leave one per cycle
//   while out_tready is high; no score is taken until the final result of
//   the set is delivered.
// Reset: synchronous, active low; clears the item count and the overflow
//   flag and returns to loading. Score cells need no reset.
// Stall: while out_tready is low the current result holds steady.
module relative_rank_assigner_top #(
  parameter int MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] score
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [5:0] position, [12:6] place, [14:13] medal, [15] zero
  output logic        out_tuser,  // [0] overflow
  output logic        out_tlast
);

  rra_pkg::ctrl_cmd_t  cmd;
  rra_pkg::dp_status_t status;

  logic [rra_pkg::POSITION_W-1:0] res_position;
  logic [rra_pkg::PLACE_W-1:0]    res_place;
  logic [rra_pkg::MEDAL_W-1:0]    res_medal;
  logic                           res_overflow;

  // Sequencer
  rra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // Cells and rank counting
  rra_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_score     (in_tdata),
    .res_position (res_position),
    .res_place    (res_place),
    .res_medal    (res_medal),
    .res_overflow (res_overflow)
  );

  // Result packing
  assign out_tdata = {1'b0, res_medal, res_place, res_position};
  assign out_tuser = res_overflow;
  assign out_tlast = status.last_res;

endmodule

// ----- rtl/rra_ctrl.sv -----
// Controller for the relative rank assigner: load, drain and emit phases.
// Depends on rra_pkg for the state type and the command/status structs.
module rra_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tlast,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  rra_pkg::dp_status_t    status,
  output rra_pkg::ctrl_cmd_t     cmd
);

  rra_pkg::state_t state_r;
  rra_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rra_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rra_pkg::ST_LOAD: begin
        if (in_tvalid && in_tlast) begin
          state_nxt = rra_pkg::ST_DRAIN;
        end
      end
      rra_pkg::ST_DRAIN: begin
        if (!status.busy) begin
          state_nxt = rra_pkg::ST_EMIT;
        end
      end
      rra_pkg::ST_EMIT: begin
        if (out_tready && status.last_res) begin
          state_nxt = rra_pkg::ST_LOAD;
        end
      end
      default: state_nxt = rra_pkg::ST_LOAD;
    endcase
  end

  // Outputs: handshakes and datapath commands
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    unique case (state_r)
      rra_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      rra_pkg::ST_DRAIN: begin
      end
      rra_pkg::ST_EMIT: begin
        out_tvalid = 1'b1;
        cmd.shift  = out_tready && !status.last_res;
        cmd.clear  = out_tready && status.last_res;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/rra_datapath.sv -----
// Datapath for the relative rank assigner: a row of score cells with
// per-cell compare and count, a registered popcount tree, and the result head.
// Depends on rra_pkg for widths, medal codes and the command/status structs.
module rra_datapath #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rra_pkg::ctrl_cmd_t                  cmd,
  output rra_pkg::dp_status_t                 status,
  input  logic [rra_pkg::SCORE_W-1:0]         in_score,
  output logic [rra_pkg::POSITION_W-1:0]      res_position,
  output logic [rra_pkg::PLACE_W-1:0]         res_place,
  output logic [rra_pkg::MEDAL_W-1:0]         res_medal,
  output logic                                res_overflow
);

  localparam int IDXW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNTW  = $clog2(MAX_ITEMS + 1);
  localparam int NGRP  = (MAX_ITEMS + rra_pkg::GROUP_SIZE - 1) / rra_pkg::GROUP_SIZE;
  localparam int PADW  = NGRP * rra_pkg::GROUP_SIZE;
  localparam int SUMW  = CNTW + rra_pkg::PLACE_W;

  // Set bookkeeping
  logic [CNTW-1:0]   count_r;
  logic              dropped_r;
  logic [IDXW-1:0]   idx_r;
  logic              room;
  logic [IDXW-1:0]   slot;

  // Cell row
  logic [rra_pkg::SCORE_W-1:0] score_r [MAX_ITEMS];
  logic [IDXW-1:0]             late_r  [MAX_ITEMS];  // later scores strictly above
  logic [IDXW-1:0]             early_r [MAX_ITEMS];  // earlier scores equal or above
  logic [MAX_ITEMS-1:0]        ge;

  // Popcount pipeline
  logic [MAX_ITEMS-1:0]        ge_r;
  logic                        p1_vld_r;
  logic [IDXW-1:0]             p1_slot_r;
  logic [rra_pkg::GROUP_W-1:0] grp_r   [NGRP];
  logic [rra_pkg::GROUP_W-1:0] grp_nxt [NGRP];
  logic                        p2_vld_r;
  logic [IDXW-1:0]             p2_slot_r;
  logic [PADW-1:0]             ge_pad;
  logic [CNTW-1:0]             total;

  logic [SUMW-1:0]             place_full;
  logic [CNTW-1:0]             idx_inc;

  assign room = count_r < CNTW'(MAX_ITEMS);
  assign slot = count_r[IDXW-1:0];

  // Cells: compare, count update, store, and shift of the counts toward the head
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic valid;
    assign valid = count_r > CNTW'(i);
    assign ge[i] = valid && ($signed(score_r[i]) >= $signed(in_score));

    always_ff @(posedge clk) begin
      if (cmd.load && room && valid && !ge[i]) begin
        late_r[i] <= late_r[i] + 1'b1;
      end else if (cmd.load && room && slot == IDXW'(i)) begin
        score_r[i] <= in_score;
        late_r[i]  <= '0;
      end else if (cmd.shift && i < MAX_ITEMS - 1) begin
        late_r[i] <= late_r[(i < MAX_ITEMS - 1) ? i + 1 : i];
      end
      if (p2_vld_r && p2_slot_r == IDXW'(i)) begin
        early_r[i] <= total[IDXW-1:0];
      end else if (cmd.shift && i < MAX_ITEMS - 1) begin
        early_r[i] <= early_r[(i < MAX_ITEMS - 1) ? i + 1 : i];
      end
    end
  end

  // Group sums of the registered compare bits
  always_comb begin
    ge_pad = '0;
    ge_pad[MAX_ITEMS-1:0] = ge_r;
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < rra_pkg::GROUP_SIZE; j++) begin
        grp_nxt[g] = grp_nxt[g] + rra_pkg::GROUP_W'(ge_pad[g * rra_pkg::GROUP_SIZE + j]);
      end
    end
  end

  // Total of the group sums
  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + CNTW'(grp_r[g]);
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      ge_r      <= ge;
      p1_slot_r <= slot;
    end
    if (p1_vld_r) begin
      grp_r     <= grp_nxt;
      p2_slot_r <= p1_slot_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
      idx_r     <= '0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
    end else begin
      p1_vld_r <= cmd.load && room;
      p2_vld_r <= p1_vld_r;
      if (cmd.clear) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
        idx_r     <= '0;
      end else begin
        if (cmd.load && room) begin
          count_r <= count_r + 1'b1;
        end else if (cmd.load) begin
          dropped_r <= 1'b1;
        end
        if (cmd.shift) begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  // Result head: always cell zero
  assign place_full   = SUMW'(early_r[0]) + SUMW'(late_r[0]) + 1'b1;
  assign res_place    = place_full[rra_pkg::PLACE_W-1:0];
  assign res_position = rra_pkg::POSITION_W'(idx_r);
  assign res_overflow = dropped_r;
  assign idx_inc      = CNTW'(idx_r) + 1'b1;

  always_comb begin
    res_medal = rra_pkg::MEDAL_NONE;
    if (place_full == SUMW'(1)) begin
      res_medal = rra_pkg::MEDAL_GOLD;
    end else if (place_full == SUMW'(2)) begin
      res_medal = rra_pkg::MEDAL_SILVER;
    end else if (place_full == SUMW'(3)) begin
      res_medal = rra_pkg::MEDAL_BRONZE;
    end
  end

  assign status.busy     = p1_vld_r || p2_vld_r;
  assign status.last_res = idx_inc == count_r;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_shift_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> !p1_vld_r && !p2_vld_r)
    else $error("results shifted while rank counts still pending");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> count_r == '0 && !dropped_r && idx_r == '0)
    else $error("set not cleared after final result");

  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    p1_vld_r |=> p2_vld_r)
    else $error("popcount pipeline lost an entry");

endmodule
